/* rtl/core/fps_pkg.sv */
// shared types and constants for the fifo process scheduler
// no dependencies; imported by fps_ptab, fps_rdq, fifo_process_scheduler, fps_checker and the testbench top

package fps_pkg;

    // stream payload widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    // request opcodes
    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_READY   = 3'd1,
        OP_PREEMPT = 3'd2,
        OP_BLOCK   = 3'd3,
        OP_SCHED   = 3'd4
    } t_opcode;

    // process states held in the process table
    typedef enum logic [1:0] {
        PS_UNUSED  = 2'd0,
        PS_READY   = 2'd1,
        PS_RUNNING = 2'd2,
        PS_WAITING = 2'd3
    } t_pstate;

    // result status codes
    typedef enum logic [1:0] {
        RS_OK     = 2'd0,
        RS_REJECT = 2'd1,
        RS_EMPTY  = 2'd2,
        RS_FULL   = 2'd3
    } t_status;

    // input request, last field in the lowest bits
    typedef struct packed {
        logic [2:0] pad;
        logic [3:0] priority_in;
        logic [5:0] process_id;
        logic [2:0] opcode;
    } t_in_item;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic       pad;
        logic       next_valid;
        logic [3:0] next_process;
        t_status    status;
    } t_out_item;

    // ready queue control from the sequencer
    typedef struct packed {
        logic rd;    // read the head slot
        logic push;  // append an id at the tail
        logic pop;   // drop the head slot
    } t_rdq_ctl;

    // ready queue flags back to the sequencer
    typedef struct packed {
        logic empty;
        logic full;
    } t_rdq_flags;

endpackage

/* rtl/core/fps_ptab.sv */
// process state table: one synchronous memory with per-entry valid bits
// depends on fps_pkg; an entry never written reads as unused

module fps_ptab #(
    parameter int NUM_PROCESSES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(NUM_PROCESSES)-1:0] i_rd_addr,
    output fps_pkg::t_pstate             o_rd_state,
    input  logic                         i_wr_en,
    input  logic [$clog2(NUM_PROCESSES)-1:0] i_wr_addr,
    input  fps_pkg::t_pstate             i_wr_state
);
    import fps_pkg::*;

    t_pstate r_mem [NUM_PROCESSES];
    logic [NUM_PROCESSES-1:0] r_vld;
    t_pstate r_rd_data;
    logic    r_rd_vld;

    // memory array, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_state;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // valid bits stand for the all-unused reset of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_state = r_rd_vld ? r_rd_data : PS_UNUSED;

    // a written entry stays valid
    a_vld_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |=> r_vld[$past(i_wr_addr)])
        else $error("ptab: written entry not marked valid");

endmodule

/* rtl/core/fps_rdq.sv */
// fifo ready queue of process ids: circular memory with head, tail and count
// depends on fps_pkg; head and tail return to zero when the queue drains

module fps_rdq #(
    parameter int NUM_PROCESSES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fps_pkg::t_rdq_ctl                i_ctl,
    input  logic [$clog2(NUM_PROCESSES)-1:0] i_push_id,
    output logic [$clog2(NUM_PROCESSES)-1:0] o_head_id,
    output fps_pkg::t_rdq_flags              o_flags
);
    import fps_pkg::*;

    localparam int SW = $clog2(NUM_PROCESSES);
    localparam int CW = $clog2(NUM_PROCESSES + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_PROCESSES - 1);
    localparam logic [CW-1:0] DEPTH     = CW'(NUM_PROCESSES);

    logic [SW-1:0] r_mem [NUM_PROCESSES];
    logic [SW-1:0] r_rd_data;
    logic [SW-1:0] r_head, n_head;
    logic [SW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_flags.empty = (r_count == '0);
    assign o_flags.full  = (r_count == DEPTH);
    assign do_push = i_ctl.push && !o_flags.full;
    assign do_pop  = i_ctl.pop && !o_flags.empty;

    // id memory, synchronous read of the head slot
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_push_id;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_head_id = r_rd_data;

    // pointer and count update
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (do_push) begin
            n_tail  = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end else if (do_pop) begin
            n_count = r_count - 1'b1;
            if (r_count == CW'(1)) begin
                n_head = '0;
                n_tail = '0;
            end else begin
                n_head = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // count never passes the depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH)
        else $error("rdq: count above depth");

    // an empty queue has both pointers at slot zero
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_flags.empty |-> (r_head == '0) && (r_tail == '0))
        else $error("rdq: empty queue with stale pointers");

    // push and pop are never requested together
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.push && i_ctl.pop))
        else $error("rdq: push and pop in one cycle");

endmodule

/* rtl/core/fifo_process_scheduler.sv */
// fifo process scheduler top level: request sequencer and result register
// depends on fps_pkg, fps_ptab and fps_rdq
//
// Usage:
//   slave channel (i_s_*) takes one request per accepted item: opcode, process id
//   and priority. master channel (o_m_*) returns exactly one result per request:
//   status, next process id and its valid flag, in request order.
//   start registers an unused id as waiting, ready and preempt append the id to
//   the fifo ready queue, block marks it waiting, schedule pops the oldest id.
//   order: an accepted request is captured in the request registers, executed in
//   S_EXEC, and its result is loaded into the result register behind o_m_tvalid.
//   flow: the process table and the queue memory are read synchronously, so each
//   request has a read step and then an update and write back step; o_s_tready is
//   high only while no request is in flight, so a new request is taken only after
//   the last one is through.
//   stall: the result register keeps its item while i_m_tready is low; a finished
//   result then waits in a holding slot and o_s_tready stays low until the
//   register frees.
//   reset: synchronous, active low. all processes read as unused, the queue is
//   empty, no result is pending.

module fifo_process_scheduler #(
    parameter int NUM_PROCESSES = 16,
    parameter int TOP_PRIORITY  = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // opcode[2:0], process_id[8:3], priority_in[12:9], zero pad[15:13]
    input  logic [fps_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // status[1:0], next_process[5:2], next_valid[6], zero pad[7]
    output logic [fps_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready
);
    import fps_pkg::*;

    localparam int IW = $clog2(NUM_PROCESSES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_HOLD = 3'b100
    } t_fsm;

    t_fsm       r_state, n_state;
    t_in_item   in_item;
    t_opcode    r_op;
    logic [5:0] r_pid;
    logic [3:0] r_pri;
    t_out_item  res, r_pend, r_out;
    logic       r_out_valid;
    logic       accept, can_load, load_out;
    logic       id_ok, pri_ok;

    t_pstate    tab_state;
    logic       tab_wr_en;
    logic [IW-1:0] tab_wr_addr;
    t_pstate    tab_wr_state;

    t_rdq_ctl   q_ctl;
    t_rdq_flags q_flags;
    logic [IW-1:0] q_head_id;

    assign in_item    = t_in_item'(i_s_tdata);
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // process state table
    fps_ptab #(
        .NUM_PROCESSES(NUM_PROCESSES)
    ) u_ptab (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (in_item.process_id[IW-1:0]),
        .o_rd_state (tab_state),
        .i_wr_en    (tab_wr_en),
        .i_wr_addr  (tab_wr_addr),
        .i_wr_state (tab_wr_state)
    );

    // ready queue
    fps_rdq #(
        .NUM_PROCESSES(NUM_PROCESSES)
    ) u_rdq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (q_ctl),
        .i_push_id (r_pid[IW-1:0]),
        .o_head_id (q_head_id),
        .o_flags   (q_flags)
    );

    // capture the request, table reads are issued in the same cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= t_opcode'(in_item.opcode);
            r_pid <= in_item.process_id;
            r_pri <= in_item.priority_in;
        end
    end

    assign id_ok  = ({1'b0, r_pid} < 7'(NUM_PROCESSES));
    assign pri_ok = (r_pri <= 4'(TOP_PRIORITY));

    // decode and modify, write back in the execute cycle
    always_comb begin
        res          = '0;
        res.status   = RS_REJECT;
        tab_wr_en    = 1'b0;
        tab_wr_addr  = r_pid[IW-1:0];
        tab_wr_state = PS_WAITING;
        q_ctl        = '0;
        q_ctl.rd     = accept;
        if (r_state == S_EXEC) begin
            unique case (r_op)
                OP_START: begin
                    if (id_ok && pri_ok && tab_state == PS_UNUSED) begin
                        tab_wr_en  = 1'b1;
                        res.status = RS_OK;
                    end
                end
                OP_READY, OP_PREEMPT: begin
                    if (id_ok) begin
                        if (q_flags.full) begin
                            res.status = RS_FULL;
                        end else begin
                            q_ctl.push   = 1'b1;
                            tab_wr_en    = 1'b1;
                            tab_wr_state = PS_READY;
                            res.status   = RS_OK;
                        end
                    end
                end
                OP_BLOCK: begin
                    if (id_ok) begin
                        tab_wr_en  = 1'b1;
                        res.status = RS_OK;
                    end
                end
                OP_SCHED: begin
                    if (q_flags.empty) begin
                        res.status = RS_EMPTY;
                    end else begin
                        q_ctl.pop        = 1'b1;
                        tab_wr_en        = 1'b1;
                        tab_wr_addr      = q_head_id;
                        tab_wr_state     = PS_RUNNING;
                        res.next_process = 4'(q_head_id);
                        res.next_valid   = 1'b1;
                        res.status       = RS_OK;
                    end
                end
                default: begin
                    res.status = RS_REJECT;
                end
            endcase
        end
    end

    // sequencer
    assign can_load = !r_out_valid || i_m_tready;
    assign load_out = can_load && (r_state == S_EXEC || r_state == S_HOLD);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_EXEC;
            S_EXEC: n_state = can_load ? S_IDLE : S_HOLD;
            S_HOLD: if (can_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register and holding slot
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_pend <= res;
        end
        if (load_out) begin
            r_out <= (r_state == S_EXEC) ? res : r_pend;
        end
    end

    assign o_m_tdata  = r_out;
    assign o_m_tvalid = r_out_valid;

    // an accepted request executes in the next cycle
    a_exec_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_EXEC)
        else $error("fps: accepted request did not execute");

    // a result is held back only while the output register is occupied
    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> r_out_valid)
        else $error("fps: result held with free output register");

    // a stalled result stays put
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("fps: result changed under stall");

endmodule

/* tb/fps_checker.sv */
// result checker for the fifo process scheduler: predicts each result from the accepted requests
// depends on fps_pkg; instantiated beside the block by tb_fifo_process_scheduler
`timescale 1ns / 1ps

module fps_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [fps_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [fps_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    output int                              o_fail_count,
    output int                              o_pending
);
    import fps_pkg::*;

    localparam int NPROC   = 16;
    localparam int TOP_PRI = 7;

    // shadow copy of the process table and the ready queue
    t_pstate    proc_state [NPROC];
    logic [3:0] ready_ids  [NPROC];
    int         q_head;
    int         q_tail;
    int         q_count;

    // results still owed by the block, oldest first
    t_out_item  expected_results [$];
    int         mismatch_count;
    int         results_seen;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        mismatch_count = 0;
        results_seen   = 0;
    end

    function automatic int slot_after(int s);
        return (s == NPROC - 1) ? 0 : s + 1;
    endfunction

    // apply one request to the shadow state and return the result it gives
    function automatic t_out_item apply_request(t_in_item req);
        t_out_item  res;
        logic       id_ok;
        logic [3:0] id;
        res        = '0;
        res.status = RS_REJECT;
        id_ok      = req.process_id < NPROC;
        id         = req.process_id[3:0];
        case (req.opcode)
            OP_START: begin
                if (id_ok && req.priority_in <= TOP_PRI && proc_state[id] == PS_UNUSED) begin
                    proc_state[id] = PS_WAITING;
                    res.status     = RS_OK;
                end
            end
            OP_READY, OP_PREEMPT: begin
                if (id_ok) begin
                    if (q_count >= NPROC) begin
                        res.status = RS_FULL;
                    end else begin
                        proc_state[id]    = PS_READY;
                        ready_ids[q_tail] = id;
                        q_tail            = slot_after(q_tail);
                        q_count++;
                        res.status        = RS_OK;
                    end
                end
            end
            OP_BLOCK: begin
                if (id_ok) begin
                    proc_state[id] = PS_WAITING;
                    res.status     = RS_OK;
                end
            end
            OP_SCHED: begin
                if (q_count == 0) begin
                    res.status = RS_EMPTY;
                end else begin
                    res.next_process = ready_ids[q_head];
                    res.next_valid   = 1'b1;
                    res.status       = RS_OK;
                    proc_state[ready_ids[q_head]] = PS_RUNNING;
                    q_head = slot_after(q_head);
                    q_count--;
                    // an emptied queue starts again from slot zero
                    if (q_count == 0) begin
                        q_head = 0;
                        q_tail = 0;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] result %0d: %s got %0d, expected %0d",
                 $time, results_seen, what, got, want);
    endtask

    // compare results and predict requests as they are accepted
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < NPROC; i++) begin
                proc_state[i] = PS_UNUSED;
            end
            q_head  = 0;
            q_tail  = 0;
            q_count = 0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_out_item'(i_m_tdata);
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, status", got.status, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.next_process != want.next_process)
                        report_mismatch("next_process", got.next_process, want.next_process);
                    if (got.next_valid != want.next_valid)
                        report_mismatch("next_valid", got.next_valid, want.next_valid);
                end
                results_seen++;
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(apply_request(t_in_item'(i_s_tdata)));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatch_count;
    end

endmodule

/* tb/tb_fifo_process_scheduler.sv */
// testbench top for the fifo process scheduler: clock, reset, request and result traffic
// depends on fps_pkg, fps_checker and the fifo_process_scheduler rtl
`timescale 1ns / 1ps

module tb_fifo_process_scheduler;
    import fps_pkg::*;

    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         HOLD_CYCLES    = 150;
    localparam int         HOLD_AFTER     = 40;
    localparam int         CHUNKS         = 20;
    localparam int         CHUNK_LEN      = 20;
    localparam logic [2:0] OP_BAD_FIRST   = 3'd5;
    localparam logic [2:0] OP_BAD_LAST    = 3'd7;
    localparam int         MIX_FILL       = 0;
    localparam int         MIX_DRAIN      = 1;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    int                     fail_count;
    int                     pending;
    int                     idle_cycles = 0;
    logic                   steady = 1'b0;

    always #5 i_clk = ~i_clk;

    fifo_process_scheduler DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready)
    );

    fps_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // idle cycles before the next request or result, none in steady stretches
    function automatic int draw_gap();
        if (steady || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // mostly in-range ids, now and then any 6-bit value
    function automatic logic [5:0] pick_pid();
        if ($urandom_range(0, 9) == 0)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, 15));
    endfunction

    // opcode mix: fill leans on appends, drain on schedule
    function automatic logic [2:0] pick_opcode(int mix);
        int r;
        r = $urandom_range(0, 99);
        if (mix == MIX_FILL)
            return (r < 85) ? (r[0] ? OP_READY : OP_PREEMPT) :
                   (r < 90) ? OP_START : (r < 94) ? OP_BLOCK :
                   (r < 98) ? OP_SCHED : 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
        if (mix == MIX_DRAIN)
            return (r < 70) ? OP_SCHED : (r < 80) ? (r[0] ? OP_READY : OP_PREEMPT) :
                   (r < 88) ? OP_BLOCK : (r < 94) ? OP_START :
                   3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
        return (r < 35) ? (r[0] ? OP_READY : OP_PREEMPT) : (r < 65) ? OP_SCHED :
               (r < 78) ? OP_START : (r < 90) ? OP_BLOCK :
               3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
    endfunction

    // offer one request and hold it until the block takes it
    task automatic send_request(input logic [2:0] op, input logic [5:0] pid,
                                input logic [3:0] pri);
        t_in_item req;
        int       gap;
        req             = '0;
        req.opcode      = op;
        req.process_id  = pid;
        req.priority_in = pri;
        gap             = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // result side: random stalls, one long hold-off to back the block up
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (taken == HOLD_AFTER) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = draw_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            taken++;
        end
    end

    // no request or result moving for too long ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL fifo_process_scheduler");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // request stream: directed corner cases, then random chunks
    initial begin : request_source
        int mix;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // schedule on an empty queue
        send_request(OP_SCHED,   6'd0,  4'd0);
        // start: good, already used, id out of range, priority too high
        send_request(OP_START,   6'd0,  4'd0);
        send_request(OP_START,   6'd15, 4'd7);
        send_request(OP_START,   6'd15, 4'd1);
        send_request(OP_START,   6'd16, 4'd0);
        send_request(OP_START,   6'd63, 4'd15);
        send_request(OP_START,   6'd3,  4'd8);
        // appends, with the same id queued twice, then a block
        send_request(OP_READY,   6'd0,  4'd0);
        send_request(OP_PREEMPT, 6'd15, 4'd15);
        send_request(OP_READY,   6'd0,  4'd9);
        send_request(OP_BLOCK,   6'd15, 4'd0);
        // ids out of range on ready, preempt and block
        send_request(OP_BLOCK,   6'd63, 4'd0);
        send_request(OP_READY,   6'd40, 4'd0);
        send_request(OP_PREEMPT, 6'd16, 4'd0);
        // drain to empty, then reuse from slot zero
        send_request(OP_SCHED,   6'd63, 4'd15);
        send_request(OP_SCHED,   6'd0,  4'd0);
        send_request(OP_SCHED,   6'd0,  4'd0);
        send_request(OP_SCHED,   6'd0,  4'd0);
        send_request(OP_PREEMPT, 6'd9,  4'd0);
        send_request(OP_SCHED,   6'd0,  4'd0);
        // unknown opcodes
        for (int op = OP_BAD_FIRST; op <= OP_BAD_LAST; op++)
            send_request(3'(op), 6'd63, 4'd15);

        // random chunks, each with its own opcode mix and idle setting
        for (int c = 0; c < CHUNKS; c++) begin
            mix    = $urandom_range(0, 2);
            steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < CHUNK_LEN; k++)
                send_request(pick_opcode(mix), pick_pid(), 4'($urandom_range(0, 15)));
        end
        steady   <= 1'b0;
        s_tvalid <= 1'b0;

        // wait for every owed result, then let the block settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS fifo_process_scheduler");
        else
            $display("FAIL fifo_process_scheduler");
        $finish;
    end

endmodule
